// ===== rtl/assert_macros.svh =====
// assertion macros for the led indicator pattern driver
// used by the top level, expects clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define LIPD_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the next cycle
`define LIPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lipd_pkg.sv =====
// shared types and constants for the led indicator pattern driver
// no dependencies
`default_nettype none

package lipd_pkg;

  localparam int TIME_W  = 32;
  localparam int DUR_W   = 16;
  localparam int COUNT_W = 8;
  localparam int MODE_W  = 3;
  localparam int IDX_W   = 2;

  localparam int unsigned MAX_PULSES = 255;

  typedef enum logic [1:0] {
    ACT_POLL  = 2'd0,
    ACT_FLASH = 2'd1,
    ACT_PULSE = 2'd2
  } action_t;

  typedef enum logic [IDX_W-1:0] {
    REG_FLASH_DURATION = 2'd0,
    REG_PULSE_ON_TIME  = 2'd1,
    REG_PULSE_GAP_TIME = 2'd2,
    REG_BG_MODE        = 2'd3
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    BG_NONE        = 3'd0,
    BG_LINKED      = 3'd1,
    BG_SEARCHING   = 3'd2,
    BG_UPLINK_DOWN = 3'd3,
    BG_COLLISION   = 3'd4
  } bg_mode_t;

  typedef struct packed {
    logic [DUR_W-1:0] flash_duration;
    logic [DUR_W-1:0] pulse_on_time;
    logic [DUR_W-1:0] pulse_gap_time;
    bg_mode_t         background_mode;
  } cfg_t;

  typedef struct packed {
    logic               flash_active;
    logic               pulse_train_active;
    logic [COUNT_W-1:0] pulses_left;
  } status_t;

  localparam logic [DUR_W-1:0] FLASH_DURATION_RST = 16'd200;
  localparam logic [DUR_W-1:0] PULSE_ON_TIME_RST  = 16'd150;
  localparam logic [DUR_W-1:0] PULSE_GAP_TIME_RST = 16'd150;

  // reciprocal multipliers: floor(x / d) = (x * M) >> S, exact over the reduced operand
  // 500 ms: x = t >> 2, d = 125
  localparam logic [31:0] MAGIC_500 = 32'd1099511628;
  localparam int          SHIFT_500 = 37;
  // 150 ms: x = t >> 1, d = 75
  localparam logic [31:0] MAGIC_150 = 32'd3665038760;
  localparam int          SHIFT_150 = 38;
  // 80 ms: x = t >> 4, d = 5
  localparam logic [31:0] MAGIC_80  = 32'd429496730;
  localparam int          SHIFT_80  = 31;

endpackage

`default_nettype wire

// ===== rtl/lipd_if.sv =====
// handshake channel interfaces: command in, led level out, register writes
// depends on lipd_pkg
`default_nettype none

interface lipd_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [lipd_pkg::TIME_W-1:0] now_ms;
  logic [lipd_pkg::COUNT_W-1:0] pulse_count;

  modport source (output valid, output action, output now_ms, output pulse_count,
                  input ready);
  modport sink (input valid, input action, input now_ms, input pulse_count,
                output ready);
endinterface

interface lipd_led_if;
  logic valid;
  logic ready;
  logic led_level;

  modport source (output valid, output led_level, input ready);
  modport sink (input valid, input led_level, output ready);
endinterface

interface lipd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lipd_pkg::IDX_W-1:0] index;
  logic [lipd_pkg::DUR_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/led_indicator_pattern_driver.sv =====
// led indicator pattern driver, top level
// a poll result passes the input, second and output registers before it reaches led
// throughput: one command per cycle while the led output is not stalled; set by the timer update in lipd_core
// commands without a result (flash, pulse, unknown) still take one pipeline slot
// reset: synchronous rst clears timers and pipeline, registers return to their defaults
// depends on lipd_pkg, lipd_if, lipd_bgwave, lipd_core, assert_macros.svh
`default_nettype none

module led_indicator_pattern_driver (
  input  wire        clk,
  input  wire        rst,
  lipd_cmd_if.sink   cmd,
  lipd_led_if.source led,
  lipd_cfg_if.sink   cfg
);
  import lipd_pkg::*;
  `include "assert_macros.svh"

  cfg_t cfg_regs;

  logic               s1_valid;
  action_t            s1_action;
  logic [TIME_W-1:0]  s1_t;
  logic [COUNT_W-1:0] s1_count;

  logic               s2_valid;
  action_t            s2_action;
  logic [TIME_W-1:0]  s2_t;
  logic [COUNT_W-1:0] s2_count;

  logic out_valid;
  logic out_level;

  logic    out_free, s2_fire, s2_free, s1_move, accept;
  logic    bg_level;
  logic    res_valid, res_level;
  status_t status;

  assign out_free = !out_valid || led.ready;
  assign s2_fire  = s2_valid && out_free;
  assign s2_free  = !s2_valid || s2_fire;
  assign s1_move  = s1_valid && s2_free;
  assign cmd.ready = !s1_valid || s2_free;
  assign accept   = cmd.valid && cmd.ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.flash_duration  <= FLASH_DURATION_RST;
      cfg_regs.pulse_on_time   <= PULSE_ON_TIME_RST;
      cfg_regs.pulse_gap_time  <= PULSE_GAP_TIME_RST;
      cfg_regs.background_mode <= BG_NONE;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_FLASH_DURATION: cfg_regs.flash_duration <= cfg.data;
        REG_PULSE_ON_TIME:  cfg_regs.pulse_on_time  <= cfg.data;
        REG_PULSE_GAP_TIME: cfg_regs.pulse_gap_time <= cfg.data;
        REG_BG_MODE:        cfg_regs.background_mode <= bg_mode_t'(cfg.data[MODE_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= action_t'(cmd.action);
      s1_t      <= cmd.now_ms;
      s1_count  <= cmd.pulse_count;
    end
  end

  // second stage holds the item while the background wave is registered beside it
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (s2_fire) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_action <= s1_action;
      s2_t      <= s1_t;
      s2_count  <= s1_count;
    end
  end

  lipd_bgwave u_bgwave (
    .clk   (clk),
    .load  (s1_move),
    .mode  (cfg_regs.background_mode),
    .t     (s1_t),
    .level (bg_level)
  );

  lipd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (s2_fire),
    .action    (s2_action),
    .t         (s2_t),
    .count     (s2_count),
    .bg_level  (bg_level),
    .cfg       (cfg_regs),
    .res_valid (res_valid),
    .res_level (res_level),
    .status    (status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire) begin
      out_valid <= res_valid;
    end else if (led.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_level <= res_level;
    end
  end

  assign led.valid     = out_valid;
  assign led.led_level = out_level;

  `LIPD_ASSERT_NEXT(a_poll_gives_result, s2_fire && res_valid, led.valid, "poll item lost")
  `LIPD_ASSERT_NEXT(a_s1_held, s1_valid && !s1_move, s1_valid, "stalled item dropped")
  `LIPD_ASSERT(a_train_has_pulses, !(status.pulse_train_active && status.pulses_left == '0),
    "pulse train active with no pulses left")

endmodule

`default_nettype wire

// ===== rtl/lipd_bgwave.sv =====
// background square wave: parity of now / half-period via one reciprocal multiply
// depends on lipd_pkg, result registered on load
`default_nettype none

module lipd_bgwave (
  input  wire                          clk,
  input  wire                          load,
  input  wire lipd_pkg::bg_mode_t      mode,
  input  wire [lipd_pkg::TIME_W-1:0]   t,
  output logic                         level
);
  import lipd_pkg::*;

  logic [31:0] x;
  logic [31:0] m;
  logic [63:0] prod;
  logic        wave;

  always_comb begin
    x = '0;
    m = '0;
    case (mode)
      BG_SEARCHING: begin
        x = {2'b00, t[31:2]};
        m = MAGIC_500;
      end
      BG_UPLINK_DOWN: begin
        x = {1'b0, t[31:1]};
        m = MAGIC_150;
      end
      BG_COLLISION: begin
        x = {4'b0000, t[31:4]};
        m = MAGIC_80;
      end
      default: begin
      end
    endcase
  end

  assign prod = {32'd0, x} * {32'd0, m};

  // level is on while the quotient is even
  always_comb begin
    case (mode)
      BG_SEARCHING:   wave = ~prod[SHIFT_500];
      BG_UPLINK_DOWN: wave = ~prod[SHIFT_150];
      BG_COLLISION:   wave = ~prod[SHIFT_80];
      default:        wave = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      level <= wave;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lipd_core.sv =====
// flash and pulse train timers, led level decision for one command
// depends on lipd_pkg
`default_nettype none

module lipd_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          fire,
  input  wire lipd_pkg::action_t       action,
  input  wire [lipd_pkg::TIME_W-1:0]   t,
  input  wire [lipd_pkg::COUNT_W-1:0]  count,
  input  wire                          bg_level,
  input  wire lipd_pkg::cfg_t          cfg,
  output logic                         res_valid,
  output logic                         res_level,
  output lipd_pkg::status_t            status
);
  import lipd_pkg::*;

  logic               flash_active, flash_active_next;
  logic [TIME_W-1:0]  flash_start_time, flash_start_time_next;
  logic               pulse_train_active, pulse_train_active_next;
  logic               pulse_in_on_phase, pulse_in_on_phase_next;
  logic [COUNT_W-1:0] pulses_left, pulses_left_next;
  logic [TIME_W-1:0]  phase_start_time, phase_start_time_next;

  logic [TIME_W-1:0]  flash_elapsed;
  logic [TIME_W-1:0]  phase_elapsed;
  logic [DUR_W-1:0]   phase_len;
  logic [COUNT_W-1:0] count_sat;
  logic [COUNT_W-1:0] pulses_dec;
  logic               flash_on;

  assign flash_elapsed = t - flash_start_time;
  assign phase_elapsed = t - phase_start_time;
  assign phase_len     = pulse_in_on_phase ? cfg.pulse_on_time : cfg.pulse_gap_time;
  assign count_sat     = (int'(count) > MAX_PULSES) ? COUNT_W'(MAX_PULSES) : count;
  assign pulses_dec    = (pulses_left != '0) ? pulses_left - 1'b1 : pulses_left;

  always_comb begin
    flash_active_next       = flash_active;
    flash_start_time_next   = flash_start_time;
    pulse_train_active_next = pulse_train_active;
    pulse_in_on_phase_next  = pulse_in_on_phase;
    pulses_left_next        = pulses_left;
    phase_start_time_next   = phase_start_time;
    res_valid               = 1'b0;
    res_level               = 1'b0;
    flash_on                = 1'b0;
    case (action)
      ACT_FLASH: begin
        flash_active_next     = 1'b1;
        flash_start_time_next = t;
      end
      ACT_PULSE: begin
        if (count != '0) begin
          pulse_train_active_next = 1'b1;
          pulse_in_on_phase_next  = 1'b1;
          pulses_left_next        = count_sat;
          phase_start_time_next   = t;
        end
      end
      ACT_POLL: begin
        res_valid = 1'b1;
        flash_on  = flash_active && (flash_elapsed < {16'd0, cfg.flash_duration});
        flash_active_next = flash_on;
        if (flash_on) begin
          res_level = 1'b1;
        end else if (pulse_train_active) begin
          // pulse phase is frozen while a flash runs, steps at most once per poll
          if (phase_elapsed >= {16'd0, phase_len}) begin
            phase_start_time_next = t;
            if (pulse_in_on_phase) begin
              pulse_in_on_phase_next = 1'b0;
              pulses_left_next       = pulses_dec;
              if (pulses_dec == '0) begin
                pulse_train_active_next = 1'b0;
              end
            end else begin
              pulse_in_on_phase_next = 1'b1;
            end
          end
          res_level = pulse_train_active_next && pulse_in_on_phase_next;
        end else begin
          res_level = bg_level;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_active       <= 1'b0;
      flash_start_time   <= '0;
      pulse_train_active <= 1'b0;
      pulse_in_on_phase  <= 1'b0;
      pulses_left        <= '0;
      phase_start_time   <= '0;
    end else if (fire) begin
      flash_active       <= flash_active_next;
      flash_start_time   <= flash_start_time_next;
      pulse_train_active <= pulse_train_active_next;
      pulse_in_on_phase  <= pulse_in_on_phase_next;
      pulses_left        <= pulses_left_next;
      phase_start_time   <= phase_start_time_next;
    end
  end

  assign status.flash_active       = flash_active;
  assign status.pulse_train_active = pulse_train_active;
  assign status.pulses_left        = pulses_left;

endmodule

`default_nettype wire

// ===== verif/led_indicator_pattern_driver_test.sv =====
// self-checking testbench for led_indicator_pattern_driver: flash, pulse train and
// background wave commands under random handshake pressure, checked by a built-in predictor
// depends on lipd_pkg, lipd_if and the led_indicator_pattern_driver rtl
`timescale 1ns / 1ps

module led_indicator_pattern_driver_test;
  import lipd_pkg::*;

  localparam logic [1:0]  ACT_UNUSED     = 2'd3;
  localparam logic [2:0]  BG_UNDEFINED   = 3'd7;
  localparam logic [31:0] HALF_SEARCHING = 32'd500;
  localparam logic [31:0] HALF_UPLINK    = 32'd150;
  localparam logic [31:0] HALF_COLLISION = 32'd80;
  localparam int NO_LEVEL       = -1;
  localparam int DRAIN_CYCLES   = 4;
  localparam int END_CYCLES     = 10;
  localparam int HOLDOFF_CYCLES = 120;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 108;
  localparam int PRESSURE_PHASE = 3;
  localparam int TIMEOUT_NS     = 2_000_000;

  typedef struct {
    bit          is_write;
    logic [1:0]  action;
    logic [31:0] t;
    logic [7:0]  n;
    int          typed;
    cfg_reg_t    cfg_idx;
    logic [15:0] wdata;
  } step_t;

  typedef enum int {SINK_FREE, SINK_HALF, SINK_MOSTLY, SINK_BURSTY} sink_style_t;

  logic clk = 1'b0;
  logic rst;

  lipd_cmd_if cmd_ch();
  lipd_led_if led_ch();
  lipd_cfg_if cfg_ch();

  led_indicator_pattern_driver uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .led(led_ch),
    .cfg(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [15:0] cur_flash_ms = FLASH_DURATION_RST;
  logic [15:0] cur_on_ms    = PULSE_ON_TIME_RST;
  logic [15:0] cur_gap_ms   = PULSE_GAP_TIME_RST;
  logic [2:0]  cur_bg       = BG_NONE;

  // predictor copy of the timers
  logic        flash_on   = 1'b0;
  logic [31:0] flash_t0   = '0;
  logic        train_on   = 1'b0;
  logic        train_lit  = 1'b0;
  logic [7:0]  train_left = '0;
  logic [31:0] train_t0   = '0;

  logic pending_levels[$];

  int error_count     = 0;
  int levels_checked  = 0;
  int polls_taken     = 0;
  int flashes_taken   = 0;
  int trains_taken    = 0;
  int ignored_taken   = 0;
  int writes_done     = 0;
  int holdoffs_asked  = 0;
  int holdoffs_served = 0;

  // returns 1 when the command yields a led level
  function automatic bit predict_led(input logic [1:0] act, input logic [31:0] t,
                                     input logic [7:0] n, output logic level);
    logic [31:0] elapsed;
    logic [31:0] phase_len;
    logic [31:0] quotient;
    level = 1'b0;
    if (act == ACT_FLASH) begin
      flash_on = 1'b1;
      flash_t0 = t;
      flashes_taken++;
      return 1'b0;
    end
    if (act == ACT_PULSE) begin
      if (n == 8'd0) begin
        ignored_taken++;
        return 1'b0;
      end
      // count is 8 bits wide, so it never exceeds the saturation limit
      train_on   = 1'b1;
      train_lit  = 1'b1;
      train_left = n;
      train_t0   = t;
      trains_taken++;
      return 1'b0;
    end
    if (act != ACT_POLL) begin
      ignored_taken++;
      return 1'b0;
    end
    polls_taken++;
    elapsed = t - flash_t0;
    if (flash_on && elapsed >= {16'd0, cur_flash_ms}) flash_on = 1'b0;
    if (flash_on) begin
      level = 1'b1;
    end else if (train_on) begin
      // at most one phase step per poll
      elapsed   = t - train_t0;
      phase_len = train_lit ? {16'd0, cur_on_ms} : {16'd0, cur_gap_ms};
      if (elapsed >= phase_len) begin
        train_t0 = t;
        if (train_lit) begin
          train_lit = 1'b0;
          if (train_left != 8'd0) train_left--;
          if (train_left == 8'd0) train_on = 1'b0;
        end else begin
          train_lit = 1'b1;
        end
      end
      level = train_on && train_lit;
    end else begin
      case (cur_bg)
        BG_SEARCHING:   quotient = t / HALF_SEARCHING;
        BG_UPLINK_DOWN: quotient = t / HALF_UPLINK;
        BG_COLLISION:   quotient = t / HALF_COLLISION;
        default:        quotient = 32'd1;
      endcase
      level = ~quotient[0];
    end
    return 1'b1;
  endfunction

  function automatic step_t cmd_row(input logic [1:0] act, input logic [31:0] t,
                                    input logic [7:0] n, input int typed);
    step_t row;
    row = '{1'b0, act, t, n, typed, REG_FLASH_DURATION, 16'd0};
    return row;
  endfunction

  function automatic step_t cfg_row(input cfg_reg_t idx, input logic [15:0] val);
    step_t row;
    row = '{1'b1, ACT_POLL, 32'd0, 8'd0, NO_LEVEL, idx, val};
    return row;
  endfunction

  task automatic push_cmd(input logic [1:0] act, input logic [31:0] t,
                          input logic [7:0] n, input int typed);
    logic level;
    bit   has_level;
    cmd_ch.valid       <= 1'b1;
    cmd_ch.action      <= act;
    cmd_ch.now_ms      <= t;
    cmd_ch.pulse_count <= n;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    has_level = predict_led(act, t, n, level);
    if (has_level) pending_levels.push_back((typed == NO_LEVEL) ? level : typed[0]);
    @(negedge clk);
  endtask

  task automatic sender_pause(input int cycles);
    if (cycles > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // flash and pulse items leave no result behind, so allow the pipeline to empty too
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_FLASH_DURATION: cur_flash_ms = val;
      REG_PULSE_ON_TIME:  cur_on_ms    = val;
      REG_PULSE_GAP_TIME: cur_gap_ms   = val;
      REG_BG_MODE:        cur_bg       = val[2:0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // led result checker
  always @(posedge clk) begin : level_check
    logic want;
    if (!rst && led_ch.valid && led_ch.ready) begin
      levels_checked++;
      if (pending_levels.size() == 0) begin
        $error("led_level with no expectation waiting, actual %0b", led_ch.led_level);
        error_count++;
      end else begin
        want = pending_levels.pop_front();
        if (led_ch.led_level !== want) begin
          $error("led_level mismatch: expected %0b, actual %0b", want, led_ch.led_level);
          error_count++;
        end
      end
    end
  end

  // receiver back-pressure, with a long hold-off on request
  initial begin : led_sink
    sink_style_t style;
    int style_left;
    int hold_left;
    int stall_left;
    led_ch.ready = 1'b0;
    style      = SINK_FREE;
    style_left = 0;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (holdoffs_served != holdoffs_asked) begin
        holdoffs_served++;
        hold_left = HOLDOFF_CYCLES;
      end
      if (style_left == 0) begin
        style      = sink_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(20, 120);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        led_ch.ready <= 1'b0;
      end else begin
        case (style)
          SINK_FREE:   led_ch.ready <= 1'b1;
          SINK_HALF:   led_ch.ready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY: led_ch.ready <= ($urandom_range(0, 3) != 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              led_ch.ready <= 1'b0;
            end else begin
              led_ch.ready <= 1'b1;
              if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
            end
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    step_t       plan[$];
    logic [31:0] clock_ms;
    logic [31:0] t;
    logic [15:0] f_ms;
    logic [15:0] on_ms;
    logic [15:0] gap_ms;
    logic [2:0]  mode;
    logic [1:0]  act;
    logic [7:0]  cnt;
    int          step_max;
    int          burst_left;
    int          pick;

    rst                = 1'b1;
    cmd_ch.valid       = 1'b0;
    cmd_ch.action      = ACT_POLL;
    cmd_ch.now_ms      = '0;
    cmd_ch.pulse_count = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_FLASH_DURATION;
    cfg_ch.data        = '0;
    burst_left         = 0;

    plan = '{
      cmd_row(ACT_POLL,   32'd0,          8'd0,   0),
      cmd_row(ACT_UNUSED, 32'hFFFF_FFFF,  8'hFF,  NO_LEVEL),
      cmd_row(ACT_FLASH,  32'd1000,       8'd0,   NO_LEVEL),
      cmd_row(ACT_POLL,   32'd1199,       8'd0,   1),
      cmd_row(ACT_POLL,   32'd1200,       8'd0,   0),
      cmd_row(ACT_PULSE,  32'd1300,       8'd0,   NO_LEVEL),
      cmd_row(ACT_POLL,   32'd1300,       8'd0,   0),
      cmd_row(ACT_PULSE,  32'd2000,       8'hFF,  NO_LEVEL),
      cmd_row(ACT_POLL,   32'd2000,       8'd0,   1),
      cmd_row(ACT_FLASH,  32'd2050,       8'd0,   NO_LEVEL),
      cmd_row(ACT_POLL,   32'd2250,       8'd0,   NO_LEVEL),
      cmd_row(ACT_POLL,   32'd2400,       8'd0,   NO_LEVEL),
      cmd_row(ACT_PULSE,  32'd3000,       8'd1,   NO_LEVEL),
      cmd_row(ACT_POLL,   32'd3150,       8'd0,   NO_LEVEL),
      // flash timer across the 32-bit wrap
      cmd_row(ACT_FLASH,  32'hFFFF_FF9C,  8'd0,   NO_LEVEL),
      cmd_row(ACT_POLL,   32'h0000_0010,  8'd0,   NO_LEVEL),
      cmd_row(ACT_POLL,   32'd100,        8'd0,   NO_LEVEL),
      cfg_row(REG_BG_MODE, 16'(BG_SEARCHING)),
      cmd_row(ACT_POLL,   32'hFFFF_FFFF,  8'hFF,  NO_LEVEL),
      cmd_row(ACT_POLL,   32'd500,        8'd0,   0),
      cfg_row(REG_BG_MODE, 16'(BG_UPLINK_DOWN)),
      cmd_row(ACT_POLL,   32'd150,        8'd0,   0),
      cfg_row(REG_BG_MODE, 16'(BG_COLLISION)),
      cmd_row(ACT_POLL,   32'd160,        8'd0,   1),
      cfg_row(REG_BG_MODE, 16'(BG_UNDEFINED)),
      cmd_row(ACT_POLL,   32'd0,          8'd0,   0),
      // zero durations expire at the next poll
      cfg_row(REG_FLASH_DURATION, 16'd0),
      cfg_row(REG_PULSE_ON_TIME,  16'd0),
      cfg_row(REG_PULSE_GAP_TIME, 16'hFFFF),
      cfg_row(REG_BG_MODE, 16'(BG_LINKED)),
      cmd_row(ACT_FLASH,  32'd50,         8'd0,   NO_LEVEL),
      cmd_row(ACT_POLL,   32'd50,         8'd0,   0),
      cmd_row(ACT_PULSE,  32'd60,         8'd2,   NO_LEVEL),
      cmd_row(ACT_POLL,   32'd60,         8'd0,   NO_LEVEL)
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].is_write) begin
        wait_idle();
        write_reg(plan[k].cfg_idx, plan[k].wdata);
      end else begin
        push_cmd(plan[k].action, plan[k].t, plan[k].n, plan[k].typed);
        if ($urandom_range(0, 2) == 0) sender_pause($urandom_range(1, 3));
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          f_ms = FLASH_DURATION_RST; on_ms = PULSE_ON_TIME_RST;
          gap_ms = PULSE_GAP_TIME_RST; mode = BG_SEARCHING;
        end
        1: begin
          f_ms = 16'd0; on_ms = 16'd0; gap_ms = 16'd0; mode = BG_COLLISION;
        end
        2: begin
          f_ms = 16'hFFFF; on_ms = 16'hFFFF; gap_ms = 16'hFFFF; mode = BG_UPLINK_DOWN;
        end
        3: begin
          f_ms = 16'd30; on_ms = 16'd20; gap_ms = 16'd10; mode = BG_COLLISION;
        end
        4: begin
          f_ms = 16'd1; on_ms = 16'd1; gap_ms = 16'd1; mode = BG_UNDEFINED;
        end
        default: begin
          f_ms   = 16'($urandom_range(0, 400));
          on_ms  = 16'($urandom_range(0, 300));
          gap_ms = 16'($urandom_range(0, 300));
          mode   = 3'($urandom_range(0, 7));
        end
      endcase
      wait_idle();
      write_reg(REG_FLASH_DURATION, f_ms);
      write_reg(REG_PULSE_ON_TIME, on_ms);
      write_reg(REG_PULSE_GAP_TIME, gap_ms);
      // upper data bits are don't-care for the mode register
      write_reg(REG_BG_MODE, {13'($urandom), mode});

      step_max = int'(f_ms);
      if (int'(on_ms) > step_max) step_max = int'(on_ms);
      if (int'(gap_ms) > step_max) step_max = int'(gap_ms);
      step_max = step_max + 3;
      // one phase starts just short of the time wrap
      clock_ms = (ph == 2) ? 32'hFFFF_0000 : $urandom;

      if (ph == PRESSURE_PHASE) begin
        holdoffs_asked++;
        push_cmd(ACT_PULSE, clock_ms, 8'd200, NO_LEVEL);
        repeat (40) begin
          clock_ms += $urandom_range(0, step_max);
          push_cmd(ACT_POLL, clock_ms, 8'($urandom), NO_LEVEL);
        end
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (burst_left == 0) begin
          sender_pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
          burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        if ($urandom_range(0, 39) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, step_max);
        t    = clock_ms;
        pick = $urandom_range(0, 99);
        if (pick < 78) act = ACT_POLL;
        else if (pick < 87) act = ACT_FLASH;
        else if (pick < 97) act = ACT_PULSE;
        else act = ACT_UNUSED;
        // stray poll with an unrelated timestamp
        if (pick < 2) t = $urandom;
        case ($urandom_range(0, 19))
          0:       cnt = 8'd0;
          1:       cnt = 8'hFF;
          2, 3:    cnt = 8'($urandom);
          default: cnt = 8'($urandom_range(1, 3));
        endcase
        push_cmd(act, t, cnt, NO_LEVEL);
      end
    end

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d polls, %0d flashes, %0d pulse trains, %0d ignored items",
             polls_taken, flashes_taken, trains_taken, ignored_taken);
    $display("checked %0d led levels over %0d register writes", levels_checked, writes_done);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
